// ===== design/mrsc_pkg.sv =====
`default_nettype none
package mrsc_pkg;

	// CRC-16 as used on Modbus RTU: reflected polynomial, all-ones start value.
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [15:0] CrcInit = 16'hFFFF;

	// Frame layout for a read of three input registers.
	localparam int RegQty      = 3;
	localparam int FrameLen    = 5 + 2 * RegQty;
	localparam int PayloadKeep = 5;
	localparam int PayloadBase = 3;

	localparam logic [3:0] IdxFunction = 4'd1;
	localparam logic [3:0] IdxCount    = 4'd2;
	localparam logic [3:0] IdxLast     = 4'(FrameLen - 1);

	localparam logic [7:0] FuncReadInput = 8'h04;
	localparam int         ExceptionBit  = 7;
	localparam logic [7:0] ByteCountOk   = 8'(2 * RegQty);

	// Result codes.
	localparam logic [2:0] ResOk        = 3'd0;
	localparam logic [2:0] ResBadCrc    = 3'd1;
	localparam logic [2:0] ResException = 3'd2;
	localparam logic [2:0] ResWrongFunc = 3'd3;
	localparam logic [2:0] ResWrongCnt  = 3'd4;

	// One decoded result, plus a strobe that marks the beat that closes a frame.
	typedef struct packed {
		logic       done;
		logic [2:0] result_code;
		logic       activated;
		logic [1:0] gripper_status;
		logic [1:0] object_status;
		logic [3:0] fault_code;
		logic [7:0] position_request;
		logic [7:0] position_now;
		logic [7:0] motor_current;
	} res_t;

	// Folds one byte into the CRC, eight shift steps unrolled.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/mrsc_in_if.sv =====
`default_nettype none
interface mrsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface
`default_nettype wire

// ===== design/mrsc_out_if.sv =====
`default_nettype none
interface mrsc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] result_code;
	logic       activated;
	logic [1:0] gripper_status;
	logic [1:0] object_status;
	logic [3:0] fault_code;
	logic [7:0] position_request;
	logic [7:0] position_now;
	logic [7:0] motor_current;

	modport source (
		output valid, output result_code, output activated, output gripper_status,
		output object_status, output fault_code, output position_request,
		output position_now, output motor_current, input ready
	);
	modport sink (
		input valid, input result_code, input activated, input gripper_status,
		input object_status, input fault_code, input position_request,
		input position_now, input motor_current, output ready
	);
endinterface
`default_nettype wire

// ===== design/mrsc_frame_capture.sv =====
`default_nettype none
module mrsc_frame_capture
	import mrsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_start,
	output logic            at_last,
	output res_t            res
);

	logic [15:0] crc_q;
	logic [3:0]  idx_q;
	logic [7:0]  func_q;
	logic [7:0]  count_q;
	logic [7:0]  payload_q [PayloadKeep];

	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic [3:0]  eff_idx;
	logic        last_beat;

	// A frame start restarts the CRC and the byte position before this byte is taken.
	assign crc_base  = frame_start ? CrcInit : crc_q;
	assign eff_idx   = frame_start ? 4'd0 : idx_q;
	assign crc_next  = crc_byte(crc_base, data_byte);
	assign last_beat = (eff_idx == IdxLast);
	assign at_last   = (idx_q == IdxLast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CrcInit;
			idx_q   <= 4'd0;
			func_q  <= 8'h00;
			count_q <= 8'h00;
		end else if (accept) begin
			if (last_beat) begin
				crc_q <= CrcInit;
				idx_q <= 4'd0;
			end else begin
				crc_q <= crc_next;
				idx_q <= eff_idx + 4'd1;
			end
			if (eff_idx == IdxFunction) begin
				func_q <= data_byte;
			end
			if (eff_idx == IdxCount) begin
				count_q <= data_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PayloadKeep; k++) begin
			if (accept && eff_idx == 4'(PayloadBase + k)) begin
				payload_q[k] <= data_byte;
			end
		end
	end

	// The received CRC is part of the stream, so a good frame leaves the register at zero.
	always_comb begin
		res = '0;
		res.done = accept && last_beat;
		if (crc_next != 16'h0000) begin
			res.result_code = ResBadCrc;
		end else if (func_q[ExceptionBit]) begin
			res.result_code = ResException;
		end else if (func_q != FuncReadInput) begin
			res.result_code = ResWrongFunc;
		end else if (count_q != ByteCountOk) begin
			res.result_code = ResWrongCnt;
		end else begin
			res.result_code      = ResOk;
			res.activated        = payload_q[0][0];
			res.gripper_status   = payload_q[0][5:4];
			res.object_status    = payload_q[0][7:6];
			res.fault_code       = payload_q[1][3:0];
			res.position_request = payload_q[2];
			res.position_now     = payload_q[3];
			res.motor_current    = payload_q[4];
		end
	end

endmodule
`default_nettype wire

// ===== design/modbus_rtu_status_response_checker.sv =====
// The result appears on status in the cycle after the beat that carries the last CRC byte.
// Throughput: one byte beat per cycle when not stalled; one result beat per eleven byte beats at most.
// The input stalls only while the frame position sits at the last byte and the previous
// result still waits untaken; a byte with frame start set at that position waits as well.
// Reset: arst_n clears the CRC to all ones, the byte position and the header bytes to zero,
// and empties the result register; the payload bytes are not reset.
`default_nettype none
module modbus_rtu_status_response_checker
	import mrsc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	mrsc_in_if.sink     frame,
	mrsc_out_if.source  status
);

	// The byte beat is accepted on valid and ready. Ready looks at registered state and at
	// the sink's ready only: a byte can always be taken unless it would close a frame while
	// the result register still holds a result that the sink does not take in this cycle.
	// A frame start on that beat would not close a frame, but ready does not look at the
	// payload, so it waits as well.
	logic accept;
	logic at_last;
	res_t res;

	logic       out_valid_q;
	logic [2:0] result_code_q;
	logic       activated_q;
	logic [1:0] gripper_status_q;
	logic [1:0] object_status_q;
	logic [3:0] fault_code_q;
	logic [7:0] position_request_q;
	logic [7:0] position_now_q;
	logic [7:0] motor_current_q;

	assign frame.ready = !out_valid_q || status.ready || !at_last;
	assign accept      = frame.valid && frame.ready;

	// All per-byte work (CRC update, header and payload capture, final checks) sits in
	// this unit; its result strobe fires on the beat that carries the last CRC byte.
	mrsc_frame_capture u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (frame.data_byte),
		.frame_start (frame.frame_start),
		.at_last     (at_last),
		.res         (res)
	);

	// Result register. A new result may replace one that is being taken in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			result_code_q      <= res.result_code;
			activated_q        <= res.activated;
			gripper_status_q   <= res.gripper_status;
			object_status_q    <= res.object_status;
			fault_code_q       <= res.fault_code;
			position_request_q <= res.position_request;
			position_now_q     <= res.position_now;
			motor_current_q    <= res.motor_current;
		end
	end

	assign status.valid            = out_valid_q;
	assign status.result_code      = result_code_q;
	assign status.activated        = activated_q;
	assign status.gripper_status   = gripper_status_q;
	assign status.object_status    = object_status_q;
	assign status.fault_code       = fault_code_q;
	assign status.position_request = position_request_q;
	assign status.position_now     = position_now_q;
	assign status.motor_current    = motor_current_q;

`ifndef SYNTHESIS
	// A frame never closes while an untaken result sits in the result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (!out_valid_q || status.ready))
		else $error("result register overwritten before it was taken");

	// An error result carries no decoded status.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && status.result_code != ResOk) |->
		(status.activated == 1'b0 && status.gripper_status == 2'd0 &&
		 status.object_status == 2'd0 && status.fault_code == 4'd0 &&
		 status.position_request == 8'd0 && status.position_now == 8'd0 &&
		 status.motor_current == 8'd0))
		else $error("error result with nonzero status fields");

	// A result beat is always followed by a fresh frame position and a valid result on status.
	a_restart_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> (!at_last && status.valid))
		else $error("frame position or result valid wrong after a frame closed");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_modbus_rtu_status_response_checker.sv =====
`timescale 1ns / 1ps

// Checks the Modbus RTU status response checker from its two ports. Byte beats go in on
// the frame channel and decoded status beats come out on the status channel. Every
// accepted byte is folded into a local decoder, and every status beat that it predicts
// is queued. Each status beat that leaves the block is compared with the oldest entry
// of that queue.
module tb_modbus_rtu_status_response_checker
	import mrsc_pkg::*;
();

	// One decoded status beat, laid out like the status channel payload.
	typedef struct packed {
		logic [2:0] code;
		logic       activated;
		logic [1:0] gripper;
		logic [1:0] objstat;
		logic [3:0] fault;
		logic [7:0] pos_req;
		logic [7:0] pos_now;
		logic [7:0] current;
	} status_rec_t;

	// Where a directed byte comes from. The two CRC bytes are filled in while the table
	// is walked, so that a frame can carry a correct CRC without a literal typed for it.
	typedef enum logic [1:0] {SrcData, SrcCrcLo, SrcCrcHi} byte_src_t;

	// One row of the directed table. A row that closes a frame may carry a typed status.
	typedef struct {
		logic [7:0]  data;
		bit          start;
		byte_src_t   src;
		bit          typed;
		status_rec_t want;
	} row_t;

	// Flavors of the random frames.
	typedef enum int {
		FrameGood, FrameException, FrameBadFunc, FrameBadCount, FrameCorrupt, FrameCut
	} frame_kind_t;

	localparam int RandomBytes = 425;

	logic clk = 1'b0;
	logic arst_n;

	mrsc_in_if  frame_if ();
	mrsc_out_if status_if ();

	modbus_rtu_status_response_checker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.status (status_if)
	);

	always #5 clk = ~clk;

	// Local copy of the decoder state: running CRC, position in the frame, header bytes
	// and the five payload bytes that are kept.
	logic [15:0] rx_crc;
	logic [3:0]  rx_pos;
	logic [7:0]  rx_func;
	logic [7:0]  rx_count;
	logic [7:0]  rx_payload [PayloadKeep];

	status_rec_t pending_status [$];
	row_t        dir_rows [$];

	// A typed status for the beat on the wire, set by the directed walker.
	bit          beat_typed;
	status_rec_t beat_want;

	int mismatches;
	int bytes_sent;
	int bytes_seen;
	int status_seen;
	int code_hits [5];

	// Counters of the idle-free stretches, one for each side.
	int src_calm;
	int sink_calm;

	// CRC-16 over one byte, least significant bit first.
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		logic        lsb;
		acc = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			lsb = acc[0];
			acc = acc >> 1;
			if (lsb) begin
				acc = acc ^ CrcPoly;
			end
		end
		return acc;
	endfunction

	// Folds one accepted byte into the local decoder. When the byte closes a frame, the
	// decoded status comes back with got set.
	task automatic decode_byte(input logic [7:0] b, input logic s, output bit got,
			output status_rec_t r);
		got = 1'b0;
		r = '0;
		// A set start flag throws away whatever frame was under way.
		if (s) begin
			rx_crc = CrcInit;
			rx_pos = '0;
		end
		rx_crc = crc16_fold(rx_crc, b);
		if (rx_pos == IdxFunction) begin
			rx_func = b;
		end else if (rx_pos == IdxCount) begin
			rx_count = b;
		end else if (rx_pos >= PayloadBase && rx_pos < PayloadBase + PayloadKeep) begin
			rx_payload[rx_pos - PayloadBase] = b;
		end
		// The sixth payload byte and the CRC bytes only feed the CRC.
		if (rx_pos != IdxLast) begin
			rx_pos = rx_pos + 4'd1;
			return;
		end
		got = 1'b1;
		// Because the CRC travels low byte first, a good frame leaves the register at zero.
		if (rx_crc != 16'h0000) begin
			r.code = ResBadCrc;
		end else if (rx_func[ExceptionBit]) begin
			r.code = ResException;
		end else if (rx_func != FuncReadInput) begin
			r.code = ResWrongFunc;
		end else if (rx_count != ByteCountOk) begin
			r.code = ResWrongCnt;
		end else begin
			r.code = ResOk;
			r.activated = rx_payload[0][0];
			r.gripper = rx_payload[0][5:4];
			r.objstat = rx_payload[0][7:6];
			r.fault = rx_payload[1][3:0];
			r.pos_req = rx_payload[2];
			r.pos_now = rx_payload[3];
			r.current = rx_payload[4];
		end
		// After a status the next byte starts a new frame, with or without a start flag.
		rx_crc = CrcInit;
		rx_pos = '0;
	endtask

	task automatic note_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			note_mismatch($sformatf("status beat %0d: %s is %0h, expected %0h",
				status_seen, name, got, want));
		end
	endtask

	// Appends one row to the directed table.
	task automatic add_row(input row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endtask

	// Draws the idle cycles before the next beat of one side. Now and then a side runs
	// a stretch of beats with no idling at all.
	task automatic pick_gap(inout int calm, output int gap);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 8);
		end
	endtask

	// Drives one byte beat. It is entered at a falling edge and returns at the falling
	// edge after the beat was taken. With no idle cycles valid simply stays high, so it
	// is never lowered and raised within one time step.
	task automatic put_byte(input logic [7:0] b, input logic s);
		int gap;
		pick_gap(src_calm, gap);
		if (gap > 0) begin
			frame_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_if.valid <= 1'b1;
		frame_if.data_byte <= b;
		frame_if.frame_start <= s;
		do @(posedge clk); while (frame_if.ready !== 1'b1);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Builds one random frame of the given flavor and sends it. Only the first byte may
	// carry the start flag.
	task automatic send_frame(input frame_kind_t kind, input logic s);
		logic [7:0]  fb [FrameLen];
		logic [15:0] c;
		int          len;
		int          k;
		fb[0] = 8'($urandom);
		fb[1] = FuncReadInput;
		fb[2] = ByteCountOk;
		for (k = PayloadBase; k < FrameLen - 2; k++) begin
			fb[k] = 8'($urandom);
		end
		case (kind)
			FrameException: begin
				// Either the usual exception echo of function 4, or any code with the top bit.
				fb[1] = ($urandom_range(0, 1) == 1) ? FuncReadInput : 8'($urandom);
				fb[1][ExceptionBit] = 1'b1;
				fb[2] = ($urandom_range(0, 1) == 1) ? ByteCountOk : 8'($urandom);
			end
			FrameBadFunc: begin
				do begin
					fb[1] = 8'($urandom);
					fb[1][ExceptionBit] = 1'b0;
				end while (fb[1] == FuncReadInput);
				fb[2] = ($urandom_range(0, 1) == 1) ? ByteCountOk : 8'($urandom);
			end
			FrameBadCount: begin
				do fb[2] = 8'($urandom); while (fb[2] == ByteCountOk);
			end
			default: begin
			end
		endcase
		c = CrcInit;
		for (k = 0; k < FrameLen - 2; k++) begin
			c = crc16_fold(c, fb[k]);
		end
		fb[FrameLen - 2] = c[7:0];
		fb[FrameLen - 1] = c[15:8];
		// A single flipped bit anywhere in the frame is always caught by the CRC.
		if (kind == FrameCorrupt) begin
			k = $urandom_range(0, FrameLen - 1);
			fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		len = (kind == FrameCut) ? $urandom_range(1, FrameLen - 1) : FrameLen;
		for (k = 0; k < len; k++) begin
			put_byte(fb[k], (k == 0) ? s : 1'b0);
		end
	endtask

	// Result side: for each status beat it draws a number of cycles with ready low, then
	// holds ready high until a beat is taken.
	initial begin : result_sink
		int gap;
		status_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			pick_gap(sink_calm, gap);
			if (gap > 0) begin
				status_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			status_if.ready <= 1'b1;
			do @(posedge clk); while (status_if.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Watches both channels at the rising edge. All inputs change at the falling edge, so
	// the values seen here are stable. A status beat is checked before the byte beat of the
	// same edge is decoded; the block answers in the cycle after a frame's last byte, so a
	// status can never belong to a byte taken at the same edge.
	always @(posedge clk) begin : beat_watch
		bit          got;
		status_rec_t pred;
		status_rec_t seen;
		if (arst_n === 1'b1) begin
			if (status_if.valid === 1'b1 && status_if.ready === 1'b1) begin
				seen = {status_if.result_code, status_if.activated, status_if.gripper_status,
					status_if.object_status, status_if.fault_code, status_if.position_request,
					status_if.position_now, status_if.motor_current};
				if (pending_status.size() == 0) begin
					note_mismatch($sformatf("status beat %0d arrived with nothing expected",
						status_seen));
				end else begin
					pred = pending_status.pop_front();
					check_field("result_code", 8'(seen.code), 8'(pred.code));
					check_field("activated", 8'(seen.activated), 8'(pred.activated));
					check_field("gripper_status", 8'(seen.gripper), 8'(pred.gripper));
					check_field("object_status", 8'(seen.objstat), 8'(pred.objstat));
					check_field("fault_code", 8'(seen.fault), 8'(pred.fault));
					check_field("position_request", seen.pos_req, pred.pos_req);
					check_field("position_now", seen.pos_now, pred.pos_now);
					check_field("motor_current", seen.current, pred.current);
				end
				if (seen.code < 5) begin
					code_hits[seen.code]++;
				end
				status_seen++;
			end
			if (frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
				decode_byte(frame_if.data_byte, frame_if.frame_start, got, pred);
				// A directed row with a typed status is held to that value.
				if (got) begin
					pending_status.insert(pending_status.size(),
						beat_typed ? beat_want : pred);
				end
				bytes_seen++;
			end
		end
	end

	function automatic row_t dir_row(input logic [7:0] d, input bit s, input byte_src_t src,
			input bit typed, input status_rec_t want);
		row_t r;
		r.data = d;
		r.start = s;
		r.src = src;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	initial begin : stimulus
		status_rec_t all_max;
		status_rec_t crc_fail;
		logic [15:0] gen_crc;
		logic [7:0]  crc_hi;
		logic [7:0]  b;
		bit          aligned;
		int          pick;
		int          k;
		int          n;

		// Every input is known from time zero, when reset is asserted.
		arst_n = 1'b0;
		frame_if.valid = 1'b0;
		frame_if.data_byte = 8'h00;
		frame_if.frame_start = 1'b0;
		beat_typed = 1'b0;
		beat_want = '0;
		rx_crc = CrcInit;
		rx_pos = '0;
		rx_func = 8'h00;
		rx_count = 8'h00;
		for (k = 0; k < PayloadKeep; k++) begin
			rx_payload[k] = 8'h00;
		end
		mismatches = 0;
		bytes_sent = 0;
		bytes_seen = 0;
		status_seen = 0;
		src_calm = 0;
		sink_calm = 0;
		for (k = 0; k < 5; k++) begin
			code_hits[k] = 0;
		end

		all_max = '{ResOk, 1'b1, 2'b11, 2'b11, 4'hF, 8'hFF, 8'hFF, 8'hFF};
		crc_fail = '0;
		crc_fail.code = ResBadCrc;

		// A well-formed frame with every payload bit set, so every status field is at
		// its maximum. The sixth payload byte enters only the CRC.
		add_row(dir_row(8'hFF, 1'b1, SrcData, 1'b0, '0));
		add_row(dir_row(FuncReadInput, 1'b0, SrcData, 1'b0, '0));
		add_row(dir_row(ByteCountOk, 1'b0, SrcData, 1'b0, '0));
		for (k = 0; k < 2 * RegQty; k++) begin
			add_row(dir_row(8'hFF, 1'b0, SrcData, 1'b0, '0));
		end
		add_row(dir_row(8'h00, 1'b0, SrcCrcLo, 1'b0, '0));
		add_row(dir_row(8'h00, 1'b0, SrcCrcHi, 1'b1, all_max));
		// Bytes right after a status, with no start flag, open a new frame. It is cut
		// short by a start flag, which restarts capture on a frame of all zeros. That
		// frame fails its CRC, which wins over its zero function code, and an error
		// status carries zero in every other field.
		add_row(dir_row(8'h00, 1'b0, SrcData, 1'b0, '0));
		add_row(dir_row(8'hA5, 1'b0, SrcData, 1'b0, '0));
		add_row(dir_row(8'h5A, 1'b0, SrcData, 1'b0, '0));
		add_row(dir_row(8'h00, 1'b1, SrcData, 1'b0, '0));
		for (k = 0; k < FrameLen - 2; k++) begin
			add_row(dir_row(8'h00, 1'b0, SrcData, 1'b0, '0));
		end
		add_row(dir_row(8'h00, 1'b0, SrcData, 1'b1, crc_fail));

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table. The CRC bytes of a row are taken from the CRC of the
		// bytes sent since the last start.
		gen_crc = CrcInit;
		crc_hi = 8'h00;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].start) begin
				gen_crc = CrcInit;
			end
			case (dir_rows[i].src)
				SrcCrcLo: begin
					b = gen_crc[7:0];
					crc_hi = gen_crc[15:8];
				end
				SrcCrcHi: b = crc_hi;
				default: b = dir_rows[i].data;
			endcase
			gen_crc = (dir_rows[i].src == SrcCrcHi) ? CrcInit : crc16_fold(gen_crc, b);
			beat_typed = dir_rows[i].typed;
			beat_want = dir_rows[i].want;
			put_byte(b, dir_rows[i].start);
		end
		beat_typed = 1'b0;

		// Random part. Most frames are well formed with random content and a mix of header
		// faults; the rest are corrupted, cut short or plain noise. A frame that follows a
		// clean frame end may leave its start flag low; after noise or a cut it sets it.
		aligned = 1'b1;
		while (bytes_sent < dir_rows.size() + RandomBytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_frame(FrameGood, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (pick < 55) begin
				send_frame(FrameException, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (pick < 65) begin
				send_frame(FrameBadFunc, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (pick < 75) begin
				send_frame(FrameBadCount, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (pick < 85) begin
				send_frame(FrameCorrupt, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (pick < 93) begin
				send_frame(FrameCut, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b0;
			end else begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++) begin
					put_byte(8'($urandom), ($urandom_range(0, 3) == 0));
				end
				aligned = 1'b0;
			end
		end
		frame_if.valid <= 1'b0;

		// Drain: wait for the last status, then a few more cycles so that a stray beat
		// would still be seen.
		n = 0;
		while (pending_status.size() != 0 && n < 2000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
		if (pending_status.size() != 0) begin
			note_mismatch($sformatf("%0d expected status beats never arrived",
				pending_status.size()));
		end

		$display("covered %0d byte beats and %0d status beats, %0d mismatches",
			bytes_seen, status_seen, mismatches);
		$display("status codes seen: ok %0d, bad crc %0d, exception %0d, function %0d, count %0d",
			code_hits[ResOk], code_hits[ResBadCrc], code_hits[ResException],
			code_hits[ResWrongFunc], code_hits[ResWrongCnt]);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("timeout at %0t ns", $time);
		$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/mrsc_pkg.sv
design/mrsc_in_if.sv
design/mrsc_out_if.sv
design/mrsc_frame_capture.sv
design/modbus_rtu_status_response_checker.sv
tb/tb_modbus_rtu_status_response_checker.sv
